>>> design/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg: shared types and constants
// Item structs, status codes and the ratio bound and width constants for the
// correlated color temperature block.
// ----------------------------------------------------------------------------
`default_nettype none

package cct_pkg;

  // status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SUM0 = 2'd1,
    ST_DEN0 = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  // input item
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [15:0] kelvin;
    status_t     status;
  } out_item_t;

  // integer bound on the McCamy ratio
  localparam int NLimInt = 16;

  // width of the ratio numerator and denominator magnitudes
  localparam int MagW = 60;

endpackage

`default_nettype wire

>>> design/cct_div_cell.sv
// ----------------------------------------------------------------------------
// cct_div_cell: one restoring divider cell
// Develops one fraction bit of the ratio quotient (saturated items pass unchanged) and hands the partial
// remainder, quotient and side data to the next cell every cycle with en high.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_div_cell
  import cct_pkg::*;
#(
  parameter int QW = 21
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            vld_i,
  input  wire logic [MagW-1:0] rem_i,
  input  wire logic [MagW-1:0] dsr_i,
  input  wire logic [QW-1:0]   quo_i,
  input  wire logic            neg_i,
  input  wire logic            sat_i,
  input  wire status_t         st_i,
  output logic                 vld_o,
  output logic [MagW-1:0]      rem_o,
  output logic [MagW-1:0]      dsr_o,
  output logic [QW-1:0]        quo_o,
  output logic                 neg_o,
  output logic                 sat_o,
  output status_t              st_o
);

  logic            vld_r;
  logic [MagW-1:0] rem_r, rem_nxt, dsr_r;
  logic [QW-1:0]   quo_r, quo_nxt;
  logic            neg_r, sat_r;
  status_t         st_r;
  logic [MagW:0]   sh;

  // shift, trial subtract
  always_comb begin
    sh = {rem_i, 1'b0};
    if (sat_i) begin
      rem_nxt = rem_i;
      quo_nxt = quo_i;
    end else if (sh >= {1'b0, dsr_i}) begin
      rem_nxt = MagW'(sh - {1'b0, dsr_i});
      quo_nxt = {quo_i[QW-2:0], 1'b1};
    end else begin
      rem_nxt = sh[MagW-1:0];
      quo_nxt = {quo_i[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dsr_r <= dsr_i;
      quo_r <= quo_nxt;
      neg_r <= neg_i;
      sat_r <= sat_i;
      st_r  <= st_i;
    end
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign dsr_o = dsr_r;
  assign quo_o = quo_r;
  assign neg_o = neg_r;
  assign sat_o = sat_r;
  assign st_o  = st_r;

endmodule

`default_nettype wire

>>> design/rgb_to_color_temperature.sv
// ----------------------------------------------------------------------------
// rgb_to_color_temperature: McCamy CCT from one raw RGB sample
// Matrix to XYZ, chromaticity ratio through a chain of divider cells,
// then the McCamy cubic in multiplier stages.
// ----------------------------------------------------------------------------
//  channel | ports                        | payload
//  input   | in_valid, in_stall, in_item  | red, green, blue
//  result  | out_valid, out_stall, out_item | kelvin, status
//
//  one item enters per cycle while the result side is not stalled; the items
//  pass the divider chain (one cell per fraction bit) and the cubic multipliers
//  rst_n clears all valid bits; payload registers are not reset
//  a stall on a valid result freezes the whole pipeline, and in_stall
//  is out_stall gated by out_valid
`default_nettype none

module rgb_to_color_temperature
  import cct_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_item
);

  localparam int F   = FRAC_BITS;
  localparam int QW  = F + 5;               // quotient magnitude incl. 16.0
  localparam int NW  = QW + 1;              // signed ratio
  localparam int VW  = F + 40;              // signed wide value width
  localparam int XW  = F + 20;              // signed X, Y, Z
  localparam longint CX0 = ((64'sd14282  <<< F) + 50000) / 100000;
  localparam longint CX1 = ((64'sd154924 <<< F) + 50000) / 100000;
  localparam longint CX2 = ((64'sd95641  <<< F) + 50000) / 100000;
  localparam longint CY0 = ((64'sd32466  <<< F) + 50000) / 100000;
  localparam longint CY1 = ((64'sd157837 <<< F) + 50000) / 100000;
  localparam longint CY2 = ((64'sd73191  <<< F) + 50000) / 100000;
  localparam longint CZ0 = ((64'sd68202  <<< F) + 50000) / 100000;
  localparam longint CZ1 = ((64'sd77073  <<< F) + 50000) / 100000;
  localparam longint CZ2 = ((64'sd56332  <<< F) + 50000) / 100000;
  localparam longint K0  = ((64'sd552033 <<< F) + 50) / 100;
  localparam longint LIM = longint'(NLimInt) <<< F;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: matrix products
  logic            s1_v_r;
  logic signed [XW-1:0] x_r, y_r, z_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= XW'(-CX0 * $signed({1'b0, in_item.red}) + CX1 * $signed({1'b0, in_item.green})
             - CX2 * $signed({1'b0, in_item.blue}));
      y_r <= XW'(-CY0 * $signed({1'b0, in_item.red}) + CY1 * $signed({1'b0, in_item.green})
             - CY2 * $signed({1'b0, in_item.blue}));
      z_r <= XW'(-CZ0 * $signed({1'b0, in_item.red}) + CZ1 * $signed({1'b0, in_item.green})
             + CZ2 * $signed({1'b0, in_item.blue}));
    end
  end

  // stage 2: sum, numerator and denominator
  logic            s2_v_r;
  logic signed [VW-1:0] num_r, den_r;
  status_t         s2_st_r;
  logic signed [XW+1:0] s_w;
  logic signed [VW-1:0] den_w;
  assign s_w   = (XW+2)'(x_r) + (XW+2)'(y_r) + (XW+2)'(z_r);
  assign den_w = VW'(64'sd1858 * s_w - 64'sd10000 * y_r);
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den_w;
      num_r <= VW'(64'sd10 * (64'sd1000 * x_r - 64'sd332 * s_w));
      if (s_w == 0) s2_st_r <= ST_SUM0;
      else if (den_w == 0) s2_st_r <= ST_DEN0;
      else s2_st_r <= ST_OK;
    end
  end

  // stage 3: integer quotient by compare against multiples, one cell seed
  logic [MagW-1:0] an, bn;
  assign an = MagW'(num_r[VW-1] ? -num_r : num_r);
  assign bn = MagW'(den_r[VW-1] ? -den_r : den_r);

  logic [4:0]      qi;
  logic [MagW+4:0] rm;
  logic            big;
  always_comb begin
    qi  = '0;
    big = ({5'd0, an} >= ({5'd0, bn} << 4));
    rm  = {5'd0, an};
    for (int k = 3; k >= 0; k--) begin
      if (rm >= ({5'd0, bn} << k)) begin
        rm = rm - ({5'd0, bn} << k);
        qi[k] = 1'b1;
      end
    end
  end

  logic [MagW-1:0] c_rem [0:F];
  logic [MagW-1:0] c_dsr [0:F];
  logic [QW-1:0]   c_quo [0:F];
  logic            c_vld [0:F];
  logic            c_neg [0:F];
  logic            c_sat [0:F];
  status_t         c_st  [0:F];

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld[0] <= 1'b0;
    else if (en) c_vld[0] <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_rem[0] <= big ? '0 : rm[MagW-1:0];
      c_dsr[0] <= (bn == 0) ? MagW'(1) : bn;
      c_quo[0] <= big ? QW'(LIM >>> F) : QW'(qi);
      c_neg[0] <= num_r[VW-1] ^ den_r[VW-1];
      c_sat[0] <= big;
      c_st[0]  <= s2_st_r;
    end
  end

  // divider cell chain, one fraction bit per cell
  for (genvar i = 0; i < F; i++) begin : g_cell
    cct_div_cell #(.QW(QW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(c_vld[i]), .rem_i(c_rem[i]), .dsr_i(c_dsr[i]), .quo_i(c_quo[i]),
      .neg_i(c_neg[i]), .sat_i(c_sat[i]), .st_i(c_st[i]),
      .vld_o(c_vld[i+1]), .rem_o(c_rem[i+1]), .dsr_o(c_dsr[i+1]),
      .quo_o(c_quo[i+1]), .neg_o(c_neg[i+1]), .sat_o(c_sat[i+1]), .st_o(c_st[i+1])
    );
  end

  // saturated items skipped the shifts: rescale to a full 16.0 bound
  logic [QW-1:0] qm;
  assign qm = c_sat[F] ? QW'(LIM) : c_quo[F];

  // stage a: magnitude squared
  logic          a_v_r, a_neg_r;
  status_t       a_st_r;
  logic [QW-1:0] a_n_r;
  logic [QW+3:0] a_n2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (en) a_v_r <= c_vld[F];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_n_r   <= qm;
      a_neg_r <= c_neg[F] && (qm != 0);
      a_st_r  <= c_st[F];
      a_n2_r  <= (QW+4)'(((2*QW)'(qm) * (2*QW)'(qm)) >> F);
    end
  end

  // linear term 68233*n/10 split as 6823*n + 3*n/10, the tenth by reciprocal
  localparam int     DK = F + 10;
  localparam longint DM = ((64'sd1 <<< DK) + 9) / 10;
  logic [F+5:0]    n_x3;
  logic [2*F+13:0] n_x3_m;
  assign n_x3   = {1'b0, a_n_r} + {a_n_r, 1'b0};
  assign n_x3_m = (2*F+14)'(n_x3) * (2*F+14)'(DM);

  // stage b: cube and linear term
  logic          b_v_r, b_neg_r;
  status_t       b_st_r;
  logic [QW+3:0] b_n2_r;
  logic [QW+7:0] b_n3_r;
  logic [QW+16:0] b_lin_r;
  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (en) b_v_r <= a_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_neg_r <= a_neg_r;
      b_st_r  <= a_st_r;
      b_n2_r  <= a_n2_r;
      b_n3_r  <= (QW+8)'(((2*QW+4)'(a_n2_r) * (2*QW+4)'(a_n_r)) >> F);
      b_lin_r <= (QW+17)'(a_n_r) * (QW+17)'(6823) + (QW+17)'(n_x3_m >> DK);
    end
  end

  // stage c: weighted sum of terms
  logic          d_v_r;
  status_t       d_st_r;
  logic signed [VW-1:0] d_sum_r;
  logic signed [VW-1:0] t3, t1;
  assign t3 = VW'(64'sd449 * $signed({1'b0, b_n3_r}));
  assign t1 = $signed(VW'(b_lin_r));
  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (en) d_v_r <= b_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_st_r  <= b_st_r;
      d_sum_r <= (b_neg_r ? -(t3 + t1) : (t3 + t1))
                 + VW'(64'sd3525 * $signed({1'b0, b_n2_r})) + VW'(K0);
    end
  end

  // output register: range check and status
  logic      o_v_r;
  out_item_t o_r;
  logic signed [VW-1:0] kel;
  assign kel = d_sum_r >>> F;
  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else if (en) o_v_r <= d_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (d_st_r != ST_OK) begin
        o_r.kelvin <= '0;
        o_r.status <= d_st_r;
      end else if (d_sum_r < 0) begin
        o_r.kelvin <= '0;
        o_r.status <= ST_SAT;
      end else if (kel > 65535) begin
        o_r.kelvin <= 16'hFFFF;
        o_r.status <= ST_SAT;
      end else begin
        o_r.kelvin <= kel[15:0];
        o_r.status <= ST_OK;
      end
    end
  end

  assign out_valid = o_v_r;
  assign out_item  = o_r;

  // checks
  a_stall_follow: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow result stall");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_SUM0 || out_item.status == ST_DEN0)
      |-> out_item.kelvin == 16'd0)
    else $error("error item with nonzero kelvin");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_stall) |-> $stable(out_item))
    else $error("result changed under stall");

endmodule

`default_nettype wire
